@@ rtl/ils_pkg.sv @@
// ============================================================================
// ils_pkg
// Shared widths, command and status codes, and the control/status bundles
// that join the indexed list store controller and datapath.
// ============================================================================
package ils_pkg;

    // Field widths fixed by the interface
    localparam int CMD_W   = 2;
    localparam int POS_W   = 12;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 11;

    // Default number of stored values
    localparam int CAPACITY_DEF = 1024;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;     // capture the input beat
        logic start;       // decode: set up index, issue first read
        logic shift_step;  // move one element, advance the index
        logic fill_write;  // write the new value at its position
        logic commit;      // update length, load the result registers
    } ils_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_insert;
        logic is_delete;
        logic ok;          // command is in range and not refused
        logic ins_append;  // insert at the tail: no shift needed
        logic del_tail;    // delete of the last value: no shift needed
        logic shift_last;  // current shift step is the final one
    } ils_stat_t;

endpackage

@@ rtl/indexed_list_store_core.sv @@
// ============================================================================
// indexed_list_store_core
// Ordered store of signed 32-bit values with read, insert-before and
// delete-at commands addressed by position; one result beat per command.
// ============================================================================
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------
//   input   | in_valid / in_ready    | cmd, position, data_in
//   output  | out_valid / out_ready  | status, data_out, count
//
// One command is in flight at a time. A read, an error or an unused command
// goes from decode straight to its result. A good insert moves each value
// from the tail down to its position up one slot and then writes the new
// value; a good delete moves each value after its position down one slot.
// An insert at the tail or a delete of the last value skips the shift. The
// element RAM moves one value per cycle (read one slot, write its neighbor).
// Reset clears the length; RAM contents are never read before written.
// A stalled result holds in the output register; the next beat is taken
// while it waits, and that command stalls only at its own finish.
// ============================================================================
module indexed_list_store_core
    import ils_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CMD_W-1:0]         cmd,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] data_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] data_out,
    output logic [COUNT_W-1:0]       count
);

    ils_cmd_t  ctrl_cmd;
    ils_stat_t dp_stat;

    ils_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd_o     (ctrl_cmd),
        .stat_i    (dp_stat)
    );

    ils_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .position (position),
        .data_in  (data_in),
        .status   (status),
        .data_out (data_out),
        .count    (count),
        .cmd_i    (ctrl_cmd),
        .stat_o   (dp_stat)
    );

endmodule

@@ rtl/ils_ram.sv @@
// ============================================================================
// ils_ram
// Generic single-write, single-read RAM with a registered read port.
// Read data holds until the next read enable.
// ============================================================================
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/ils_ctrl.sv @@
// ============================================================================
// ils_ctrl
// Sequencer for the indexed list store: accepts a command beat, steps the
// datapath through decode, element shifting and the final write, and holds
// the result valid until the beat is taken.
// ============================================================================
module ils_ctrl
    import ils_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output ils_cmd_t  cmd_o,
    input  ils_stat_t stat_i
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_FILL   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd_o          = '0;

        // drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_o.load_in = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd_o.start = 1'b1;
                if (stat_i.ok && stat_i.is_insert)
                begin
                    state_next = stat_i.ins_append ? S_FILL : S_SHIFT;
                end
                else if (stat_i.ok && stat_i.is_delete)
                begin
                    state_next = stat_i.del_tail ? S_FINISH : S_SHIFT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT:
            begin
                cmd_o.shift_step = 1'b1;
                if (stat_i.shift_last)
                begin
                    state_next = stat_i.is_insert ? S_FILL : S_FINISH;
                end
            end
            S_FILL:
            begin
                cmd_o.fill_write = 1'b1;
                state_next       = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    cmd_o.commit   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/ils_dp.sv @@
// ============================================================================
// ils_dp
// Datapath of the indexed list store: command registers, length counter,
// shift index, element RAM addressing and the result registers.
// ============================================================================
module ils_dp
    import ils_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [CMD_W-1:0]         cmd,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] data_in,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] data_out,
    output logic [COUNT_W-1:0]       count,
    input  ils_cmd_t                 cmd_i,
    output ils_stat_t                stat_o
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

    // Captured command beat
    logic [CMD_W-1:0]  cmd_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] data_reg;

    // Length and shift index
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;

    // Result registers
    logic [STAT_W-1:0] status_reg;
    logic [DATA_W-1:0] data_out_reg, data_out_next;
    logic [COUNT_W-1:0] count_reg;

    // RAM port signals
    logic              ram_we;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_re;
    logic [LEN_W-1:0]  rd_idx;
    logic [DATA_W-1:0] ram_rd_data;

    logic [CMP_W-1:0]  pos_ext, len_ext, idx_ext;
    logic [STAT_W-1:0] stat_code;
    logic              is_read, is_insert, is_delete;

    assign pos_ext = CMP_W'(pos_reg);
    assign len_ext = CMP_W'(len_reg);
    assign idx_ext = CMP_W'(idx_reg);

    assign is_read   = (cmd_reg == CMD_READ);
    assign is_insert = (cmd_reg == CMD_INSERT);
    assign is_delete = (cmd_reg == CMD_DELETE);

    // Range and full checks
    always_comb
    begin
        stat_code = ST_DONE;
        case (cmd_reg)
            CMD_READ, CMD_DELETE:
            begin
                if (pos_ext >= len_ext)
                begin
                    stat_code = ST_RANGE;
                end
            end
            CMD_INSERT:
            begin
                if (pos_ext > len_ext)
                begin
                    stat_code = ST_RANGE;
                end
                else if (len_ext == CMP_W'(CAPACITY))
                begin
                    stat_code = ST_FULL;
                end
            end
            default:
            begin
                stat_code = ST_DONE;
            end
        endcase
    end

    // Status toward the controller
    always_comb
    begin
        stat_o.is_insert  = is_insert;
        stat_o.is_delete  = is_delete;
        stat_o.ok         = (stat_code == ST_DONE);
        stat_o.ins_append = (pos_ext == len_ext);
        stat_o.del_tail   = (pos_ext + CMP_W'(1) == len_ext);
        stat_o.shift_last = is_insert ? (idx_ext == pos_ext + CMP_W'(1))
                                      : (idx_ext + CMP_W'(2) == len_ext);
    end

    // Shift index and read address
    always_comb
    begin
        idx_next = idx_reg;
        rd_idx   = idx_reg;
        if (cmd_i.start)
        begin
            case (cmd_reg)
                CMD_INSERT:
                begin
                    idx_next = len_reg;
                    rd_idx   = len_reg - LEN_W'(1);
                end
                CMD_DELETE:
                begin
                    idx_next = LEN_W'(pos_reg);
                    rd_idx   = LEN_W'(pos_reg) + LEN_W'(1);
                end
                default:
                begin
                    rd_idx = LEN_W'(pos_reg);
                end
            endcase
        end
        else if (cmd_i.shift_step)
        begin
            if (is_insert)
            begin
                idx_next = idx_reg - LEN_W'(1);
                rd_idx   = idx_reg - LEN_W'(2);
            end
            else
            begin
                idx_next = idx_reg + LEN_W'(1);
                rd_idx   = idx_reg + LEN_W'(2);
            end
        end
    end

    // RAM write: shifted element or the new value
    always_comb
    begin
        ram_re      = cmd_i.start || cmd_i.shift_step;
        ram_we      = cmd_i.shift_step || cmd_i.fill_write;
        ram_wr_addr = idx_reg[ADDR_W-1:0];
        ram_wr_data = ram_rd_data;
        if (cmd_i.fill_write)
        begin
            ram_wr_addr = pos_reg[ADDR_W-1:0];
            ram_wr_data = data_reg;
        end
    end

    // Length after the command and read result
    always_comb
    begin
        len_next      = len_reg;
        data_out_next = '0;
        if (stat_code == ST_DONE)
        begin
            if (is_insert)
            begin
                len_next = len_reg + LEN_W'(1);
            end
            else if (is_delete)
            begin
                len_next = len_reg - LEN_W'(1);
            end
        end
        if (is_read)
        begin
            data_out_next = (stat_code == ST_DONE) ? ram_rd_data : '1;
        end
    end

    ils_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY),
        .AW    (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_re),
        .rd_addr (rd_idx[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Length counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cmd_i.commit)
        begin
            len_reg <= len_next;
        end
    end

    // Command capture, index and result registers
    always_ff @(posedge clk)
    begin
        if (cmd_i.load_in)
        begin
            cmd_reg  <= cmd;
            pos_reg  <= position;
            data_reg <= data_in;
        end
        idx_reg <= idx_next;
        if (cmd_i.commit)
        begin
            status_reg   <= stat_code;
            data_out_reg <= data_out_next;
            count_reg    <= COUNT_W'(len_next);
        end
    end

    assign status   = status_reg;
    assign data_out = data_out_reg;
    assign count    = count_reg;

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: indexed list store core
// Drives read, insert and delete commands through the valid/ready input,
// predicts every result from a local copy of the stored sequence, and checks
// each result beat in order. A short directed part covers empty, edge and
// error cases; then random traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ils_pkg::*;

    localparam int LIST_CAP       = CAPACITY_DEF;
    localparam int POS_MAX        = (1 << POS_W) - 1;
    localparam int RANDOM_ITEMS   = 557;
    localparam int QUIET_TAIL     = 60;

    // Command code with no function; the block must ignore it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]         op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } list_cmd_t;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] value;
        logic [COUNT_W-1:0]       count;
    } list_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [CMD_W-1:0]         cmd = '0;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] data_in = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data_out;
    logic [COUNT_W-1:0]       count;

    list_cmd_t    pending_cmds[$];
    list_result_t expected_results[$];

    // Local copy of the stored sequence
    logic signed [DATA_W-1:0] model_store [0:LIST_CAP-1];
    int                       model_len = 0;

    int   plan_len = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   error_count = 0;
    logic in_taken = 1'b0;

    indexed_list_store_core #(
        .CAPACITY(LIST_CAP)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .position(position),
        .data_in(data_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .data_out(data_out),
        .count(count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one command to the local sequence and return the result it gives
    function automatic list_result_t apply_list_command(list_cmd_t c);
        list_result_t r;
        int           p;
        p = int'(c.pos);
        r.status = ST_DONE;
        r.value  = '0;
        case (c.op)
            CMD_READ:
            begin
                if (p < model_len)
                    r.value = model_store[p];
                else
                begin
                    r.status = ST_RANGE;
                    r.value  = -1;
                end
            end
            CMD_INSERT:
            begin
                if (p > model_len)
                    r.status = ST_RANGE;
                else if (model_len >= LIST_CAP)
                    r.status = ST_FULL;
                else
                begin
                    for (int k = model_len; k > p; k--)
                        model_store[k] = model_store[k-1];
                    model_store[p] = c.value;
                    model_len++;
                end
            end
            CMD_DELETE:
            begin
                if (p >= model_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (int k = p; k + 1 < model_len; k++)
                        model_store[k] = model_store[k+1];
                    model_len--;
                end
            end
            default:
            begin
            end
        endcase
        r.count = COUNT_W'(model_len);
        return r;
    endfunction

    // Queue a command and track the length it leaves behind
    task automatic queue_command(logic [CMD_W-1:0] op, int pos, logic [DATA_W-1:0] value);
        list_cmd_t c;
        c.op    = op;
        c.pos   = POS_W'(pos);
        c.value = value;
        pending_cmds.push_back(c);
        if (op == CMD_INSERT && pos <= plan_len && plan_len < LIST_CAP)
            plan_len++;
        else if (op == CMD_DELETE && pos < plan_len)
            plan_len--;
    endtask

    // Valid position in [0, hi], leaning toward the two ends
    function automatic int pick_position(int hi);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return hi;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    task automatic report_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Drive command beats and the result-side ready at the falling edge
    always @(negedge clk)
    begin : drive_channels
        list_cmd_t next_cmd;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() == 0)
                in_valid <= 1'b0;
            else if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 12);
                in_valid <= 1'b0;
            end
            else
            begin
                next_cmd = pending_cmds.pop_front();
                in_valid <= 1'b1;
                cmd      <= next_cmd.op;
                position <= next_cmd.pos;
                data_in  <= next_cmd.value;
            end
        end
        // Stall the result side in bursts, never near the end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap = recv_gap - 1;
            out_ready <= 1'b0;
        end
        else if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
        begin
            recv_gap = $urandom_range(0, 12);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Predict on each accepted command beat, check each accepted result beat
    always @(posedge clk)
    begin : watch_channels
        list_cmd_t    seen_cmd;
        list_result_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                seen_cmd.op    = cmd;
                seen_cmd.pos   = position;
                seen_cmd.value = data_in;
                expected_results.push_back(apply_list_command(seen_cmd));
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with none expected: status %0d data %0d count %0d",
                             $time, status, data_out, count);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    report_field("status", want.status, status);
                    report_field("data_out", want.value, data_out);
                    report_field("count", want.count, count);
                end
            end
        end
    end

    // Build the stimulus, release reset, and wait for the traffic to drain
    initial
    begin : run_stimulus
        int sel;
        int op_pick;

        // Empty store, unused code, and building a short list
        queue_command(CMD_READ, 0, 32'h0000_0000);
        queue_command(CMD_DELETE, 0, 32'hFFFF_FFFF);
        queue_command(CMD_INSERT, 1, 32'h1234_5678);
        queue_command(CMD_UNUSED, POS_MAX, 32'hFFFF_FFFF);
        queue_command(CMD_INSERT, 0, 32'h8000_0000);
        queue_command(CMD_INSERT, 1, 32'h7FFF_FFFF);
        queue_command(CMD_INSERT, 0, 32'hFFFF_FFFF);
        queue_command(CMD_INSERT, 1, 32'h0000_0000);
        queue_command(CMD_INSERT, POS_MAX, 32'hA5A5_5A5A);
        queue_command(CMD_INSERT, 5, 32'h0F0F_F0F0);
        queue_command(CMD_INSERT, 4, 32'h5555_AAAA);
        for (int i = 0; i < 5; i++)
            queue_command(CMD_READ, i, $urandom);
        queue_command(CMD_READ, 5, 32'h0000_0000);
        queue_command(CMD_READ, POS_MAX, 32'h0000_0000);
        // Delete at the tail, the head, and the middle
        queue_command(CMD_DELETE, 4, 32'h0000_0000);
        queue_command(CMD_DELETE, 0, 32'h0000_0000);
        queue_command(CMD_DELETE, 1, 32'h0000_0000);
        queue_command(CMD_DELETE, POS_MAX, 32'h0000_0000);
        queue_command(CMD_UNUSED, 0, 32'h0000_0000);

        // Random traffic, mostly in range, some out of range or unused
        repeat (RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 6)
            begin
                op_pick = $urandom_range(0, 3);
                queue_command(CMD_W'(op_pick), $urandom_range(plan_len + 1, POS_MAX), $urandom);
            end
            else if (sel < 48 || plan_len == 0)
                queue_command(CMD_INSERT, pick_position(plan_len), $urandom);
            else if (sel < 72)
                queue_command(CMD_DELETE, pick_position(plan_len - 1), $urandom);
            else
                queue_command(CMD_READ, pick_position(plan_len - 1), $urandom);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Hang guard
    initial
    begin
        #100_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
